// ----- rtl/core/afc_pkg.sv -----
// Package for the box culling block: widths, stream packing positions,
// item kinds and configuration register indexes.
// No dependencies; imported by aabb_frustum_region_cull, afc_visibility_sb_pkg and the testbench.
package afc_pkg;

  // Storage and field sizes.
  localparam int MAX_PLANES = 6;
  localparam int PIDX_W     = 3;
  localparam int NORM_W     = 16;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = NORM_W + COORD_W;
  localparam int ACC_W      = 50;
  localparam int OFF_SHIFT  = 14;
  localparam int AXES       = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_REGION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_FRUSTUM = 2'd2;

  // Input item packing, lowest bit first.
  localparam int IDX_LSB    = 0;
  localparam int NX_LSB     = IDX_LSB + PIDX_W;
  localparam int NY_LSB     = NX_LSB + NORM_W;
  localparam int NZ_LSB     = NY_LSB + NORM_W;
  localparam int OFF_LSB    = NZ_LSB + NORM_W;
  localparam int MINX_LSB   = OFF_LSB + COORD_W;
  localparam int MAXX_LSB   = MINX_LSB + AXES * COORD_W;
  localparam int IN_USED_W  = MAXX_LSB + AXES * COORD_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;
  localparam int IN_TUSER_W = 2;

  // Result item packing.
  localparam int OUT_USED_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // Item kinds carried on the input tuser.
  typedef enum logic [IN_TUSER_W-1:0] {
    MODE_TEST   = 2'd0,
    MODE_PLANE  = 2'd1,
    MODE_REGION = 2'd2
  } mode_t;

  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

// ----- rtl/core/aabb_frustum_region_cull.sv -----
// A test item accepted at the input shows its result on out_* after passing the
// input register, product stage, partial sum stage and output register.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Load items take effect in the first stage and give no result.
// Reset (rst_n low, synchronous) clears the planes, region, configuration registers and all valid bits.
// Box culling against a stored region box and up to six frustum planes.
// Depends on afc_pkg.
module aabb_frustum_region_cull (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input items.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata fields from bit 0: plane_index, normal_x, normal_y, normal_z, plane_offset,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero fill.
  input  logic [afc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser fields from bit 0: mode.
  input  logic [afc_pkg::IN_TUSER_W-1:0]     in_tuser,
  // Result items.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata fields from bit 0: visible, region_pass, frustum_pass, zero fill.
  output logic [afc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import afc_pkg::*;

  // Configuration registers.
  logic [PIDX_W-1:0] plane_count_r;
  logic              use_region_r;
  logic              use_frustum_r;

  // Stored planes and region.
  norm_t  plane_nrm_r [MAX_PLANES][AXES];
  coord_t plane_off_r [MAX_PLANES];
  coord_t region_lo_r [AXES];
  coord_t region_hi_r [AXES];

  // Stage 1: registered input item.
  logic              s1_valid_r;
  mode_t             s1_mode_r;
  logic [PIDX_W-1:0] s1_pidx_r;
  norm_t             s1_nrm_r [AXES];
  coord_t            s1_off_r;
  coord_t            s1_lo_r [AXES];
  coord_t            s1_hi_r [AXES];

  // Stage 2: products and stored plane offsets (test items only).
  logic   s2_valid_r;
  logic   s2_rp_r;
  prod_t  s2_prod_r [MAX_PLANES][AXES];
  coord_t s2_off_r  [MAX_PLANES];
  logic   s2_valid_nxt;
  logic   s2_rp_nxt;
  prod_t  s2_prod_nxt [MAX_PLANES][AXES];

  // Stage 3: two partial sums per plane.
  logic   s3_valid_r;
  logic   s3_rp_r;
  acc_t   s3_suma_r [MAX_PLANES];
  acc_t   s3_sumb_r [MAX_PLANES];
  acc_t   s3_suma_nxt [MAX_PLANES];
  acc_t   s3_sumb_nxt [MAX_PLANES];

  // Output register.
  logic   out_valid_r;
  logic   out_vis_r;
  logic   out_rp_r;
  logic   out_fp_r;
  logic   out_fp_nxt;
  acc_t   total [MAX_PLANES];
  logic [MAX_PLANES-1:0] plane_fail;

  logic   pipe_en;
  logic   s1_load_plane;
  logic   s1_load_region;
  logic [AXES-1:0] axis_ok;

  // The whole pipeline moves when the output register can take an item.
  assign pipe_en   = !out_valid_r || out_tready;
  assign in_tready = pipe_en;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= '0;
      use_region_r  <= 1'b0;
      use_frustum_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLANE_COUNT: plane_count_r <= cfg_wdata[PIDX_W-1:0];
        CFG_USE_REGION:  use_region_r  <= cfg_wdata[0];
        CFG_USE_FRUSTUM: use_frustum_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage 1 valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Stage 1 payload, unpacked from the stream.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_mode_r   <= mode_t'(in_tuser);
      s1_pidx_r   <= in_tdata[IDX_LSB +: PIDX_W];
      s1_nrm_r[0] <= in_tdata[NX_LSB +: NORM_W];
      s1_nrm_r[1] <= in_tdata[NY_LSB +: NORM_W];
      s1_nrm_r[2] <= in_tdata[NZ_LSB +: NORM_W];
      s1_off_r    <= in_tdata[OFF_LSB +: COORD_W];
      for (int a = 0; a < AXES; a++) begin
        s1_lo_r[a] <= in_tdata[MINX_LSB + a * COORD_W +: COORD_W];
        s1_hi_r[a] <= in_tdata[MAXX_LSB + a * COORD_W +: COORD_W];
      end
    end
  end

  // Load items update the stored state as they leave stage 1, so later
  // test items see them and earlier ones do not.
  assign s1_load_plane  = pipe_en && s1_valid_r && (s1_mode_r == MODE_PLANE);
  assign s1_load_region = pipe_en && s1_valid_r && (s1_mode_r == MODE_REGION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < MAX_PLANES; p++) begin
        plane_off_r[p] <= '0;
        for (int a = 0; a < AXES; a++) begin
          plane_nrm_r[p][a] <= '0;
        end
      end
      for (int a = 0; a < AXES; a++) begin
        region_lo_r[a] <= '0;
        region_hi_r[a] <= '0;
      end
    end else begin
      // An index beyond the stored entries matches none and is dropped.
      for (int p = 0; p < MAX_PLANES; p++) begin
        if (s1_load_plane && (int'(s1_pidx_r) == p)) begin
          plane_off_r[p] <= s1_off_r;
          for (int a = 0; a < AXES; a++) begin
            plane_nrm_r[p][a] <= s1_nrm_r[a];
          end
        end
      end
      if (s1_load_region) begin
        for (int a = 0; a < AXES; a++) begin
          region_lo_r[a] <= s1_lo_r[a];
          region_hi_r[a] <= s1_hi_r[a];
        end
      end
    end
  end

  // Stage 1 work: region overlap and the p-vertex products.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      axis_ok[a] = !((s1_hi_r[a] < region_lo_r[a]) || (s1_lo_r[a] > region_hi_r[a]));
    end
    s2_valid_nxt = s1_valid_r && (s1_mode_r == MODE_TEST);
    s2_rp_nxt    = !use_region_r || (&axis_ok);
    // A non-negative component takes the max corner, a negative one the min.
    for (int p = 0; p < MAX_PLANES; p++) begin
      for (int a = 0; a < AXES; a++) begin
        if (plane_nrm_r[p][a] >= 0) begin
          s2_prod_nxt[p][a] = prod_t'(plane_nrm_r[p][a]) * prod_t'(s1_hi_r[a]);
        end else begin
          s2_prod_nxt[p][a] = prod_t'(plane_nrm_r[p][a]) * prod_t'(s1_lo_r[a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_rp_r   <= s2_rp_nxt;
      s2_prod_r <= s2_prod_nxt;
      s2_off_r  <= plane_off_r;
    end
  end

  // Stage 2 work: x plus y, and z plus the offset scaled to the product format.
  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      s3_suma_nxt[p] = ACC_W'(s2_prod_r[p][0]) + ACC_W'(s2_prod_r[p][1]);
      s3_sumb_nxt[p] = ACC_W'(s2_prod_r[p][2]) + (ACC_W'(s2_off_r[p]) <<< OFF_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_rp_r   <= s2_rp_r;
      s3_suma_r <= s3_suma_nxt;
      s3_sumb_r <= s3_sumb_nxt;
    end
  end

  // Stage 3 work: final sum, sign test and the enabled-plane mask.
  // A plane count above the stored entries simply enables them all.
  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      total[p]      = s3_suma_r[p] + s3_sumb_r[p];
      plane_fail[p] = total[p][ACC_W-1] && (p < int'(plane_count_r));
    end
    out_fp_nxt = !use_frustum_r || !(|plane_fail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_rp_r  <= s3_rp_r;
      out_fp_r  <= out_fp_nxt;
      out_vis_r <= s3_rp_r && out_fp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_fp_r, out_rp_r, out_vis_r};

  // A test item leaving the last stage always lands in the output register.
  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && pipe_en) |=> out_valid_r)
    else $error("test item lost between stage 3 and the output register");

  // Load items never travel past stage 1.
  a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_mode_r != MODE_TEST) && pipe_en) |=> !s2_valid_r)
    else $error("load item entered the product stage");

  // With the region test off, every result reports a region pass.
  a_region_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !use_region_r) |-> out_rp_r)
    else $error("region fail reported with the region test disabled");

  // With the frustum test off, every result reports a frustum pass.
  a_frustum_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !use_frustum_r) |-> out_fp_r)
    else $error("frustum fail reported with the frustum test disabled");

endmodule

// ----- tb/afc_visibility_sb_pkg.sv -----
// Scoreboard for the box culling testbench: item field layout and a class that
// keeps the plane, region and register state and predicts each visibility result.
// Depends on afc_pkg.
package afc_visibility_sb_pkg;
  import afc_pkg::*;

  // Fields of one input item's tdata. The first member lands in the top bits,
  // so plane_index sits at bit 0 as it does on the bus.
  typedef struct packed {
    coord_t            max_z;
    coord_t            max_y;
    coord_t            max_x;
    coord_t            min_z;
    coord_t            min_y;
    coord_t            min_x;
    coord_t            offset;
    norm_t             nz;
    norm_t             ny;
    norm_t             nx;
    logic [PIDX_W-1:0] pidx;
  } cull_fields_t;

  class visibility_scoreboard;
    norm_t                 plane_normal[MAX_PLANES][AXES];
    coord_t                plane_offset[MAX_PLANES];
    coord_t                region_lo[AXES];
    coord_t                region_hi[AXES];
    logic [CFG_DATA_W-1:0] plane_count;
    logic                  region_on;
    logic                  frustum_on;
    // Each entry holds {frustum_pass, region_pass, visible}, as on out_tdata.
    logic [OUT_USED_W-1:0] expected_visibility[$];
    int                    mismatches;

    function new();
      for (int p = 0; p < MAX_PLANES; p++) begin
        plane_offset[p] = '0;
        for (int a = 0; a < AXES; a++) begin
          plane_normal[p][a] = '0;
        end
      end
      for (int a = 0; a < AXES; a++) begin
        region_lo[a] = '0;
        region_hi[a] = '0;
      end
      plane_count = '0;
      region_on   = 1'b0;
      frustum_on  = 1'b0;
      mismatches  = 0;
    endfunction

    // Register writes to an unknown index leave everything as it was.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PLANE_COUNT: plane_count = value;
        CFG_USE_REGION:  region_on   = value[0];
        CFG_USE_FRUSTUM: frustum_on  = value[0];
        default: ;
      endcase
    endfunction

    // Called for every accepted input item, in order of acceptance.
    function void note_item(logic [IN_TUSER_W-1:0] mode, cull_fields_t f);
      coord_t      lo[AXES];
      coord_t      hi[AXES];
      coord_t      corner;
      longint      acc;
      int unsigned planes;
      logic        rp;
      logic        fp;
      lo = '{f.min_x, f.min_y, f.min_z};
      hi = '{f.max_x, f.max_y, f.max_z};
      case (mode)
        MODE_PLANE: begin
          // Entries past the table are dropped.
          if (f.pidx < MAX_PLANES) begin
            plane_normal[f.pidx] = '{f.nx, f.ny, f.nz};
            plane_offset[f.pidx] = f.offset;
          end
        end
        MODE_REGION: begin
          region_lo = lo;
          region_hi = hi;
        end
        MODE_TEST: begin
          // Overlap on every axis; inverted boxes are taken as they are.
          rp = 1'b1;
          if (region_on) begin
            for (int a = 0; a < AXES; a++) begin
              if (hi[a] < region_lo[a] || lo[a] > region_hi[a]) rp = 1'b0;
            end
          end
          // Signed distance of the p-vertex, exact at scale 2^30. A zero normal
          // component picks the maximum corner.
          fp = 1'b1;
          planes = (plane_count > MAX_PLANES) ? MAX_PLANES : plane_count;
          if (frustum_on) begin
            for (int p = 0; p < planes; p++) begin
              acc = longint'(plane_offset[p]) * (longint'(1) << OFF_SHIFT);
              for (int a = 0; a < AXES; a++) begin
                corner = (plane_normal[p][a] >= 0) ? hi[a] : lo[a];
                acc += longint'(plane_normal[p][a]) * longint'(corner);
              end
              if (acc < 0) fp = 1'b0;
            end
          end
          expected_visibility.push_back({fp, rp, rp & fp});
        end
        default: ;
      endcase
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      string                 field_name[OUT_USED_W] = '{"visible", "region_pass", "frustum_pass"};
      logic [OUT_USED_W-1:0] want;
      if (expected_visibility.size() == 0) begin
        flag($sformatf("result item %b arrived with nothing outstanding", data[OUT_USED_W-1:0]));
        return;
      end
      want = expected_visibility.pop_front();
      for (int i = 0; i < OUT_USED_W; i++) begin
        if (data[i] !== want[i]) begin
          flag($sformatf("%s: expected %b, got %b", field_name[i], want[i], data[i]));
        end
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR [%0t] %s", $time, msg);
    endfunction

    function int pending();
      return expected_visibility.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_aabb_frustum_region_cull.sv -----
// Testbench for aabb_frustum_region_cull: directed and random plane, region and
// box items under several register settings and idle patterns, checked by a scoreboard.
// Depends on afc_pkg and afc_visibility_sb_pkg.
module tb_aabb_frustum_region_cull;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;
  import afc_visibility_sb_pkg::*;

  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_IDX  = 2'd3;
  localparam logic [IN_TUSER_W-1:0] MODE_UNUSED     = 2'd3;
  localparam int                    DRAIN_CYCLES    = 6;
  localparam int                    RANDOM_PHASES   = 8;
  localparam int                    ITEMS_PER_PHASE = 135;

  localparam coord_t Q_ONE    = 32'sh0001_0000;
  localparam coord_t Q_HALF   = 32'sh0000_8000;
  localparam coord_t Q_TWO    = 32'sh0002_0000;
  localparam coord_t COORD_LO = 32'sh8000_0000;
  localparam coord_t COORD_HI = 32'sh7fff_ffff;
  localparam norm_t  N_ONE    = 16'sh4000;
  localparam norm_t  N_LO     = 16'sh8000;
  localparam norm_t  N_HI     = 16'sh7fff;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // Register settings of the random phases; the extremes of plane_count included.
  int phase_planes[RANDOM_PHASES]  = '{6, 0, 7, 3, 1, 6, 5, 2};
  int phase_region[RANDOM_PHASES]  = '{1, 1, 0, 1, 1, 0, 1, 0};
  int phase_frustum[RANDOM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1};

  visibility_scoreboard sb = new();

  aabb_frustum_region_cull dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Mostly small coordinates (within +-16.0) so tests land on both sides,
  // sometimes any 32-bit value.
  function automatic coord_t rand_coord();
    if ($urandom_range(15) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 32'h20_0000) - 32'h10_0000);
  endfunction

  // Mostly within +-1.0, some zero components, sometimes any 16-bit value.
  function automatic norm_t rand_norm();
    if ($urandom_range(7) == 0) return '0;
    if ($urandom_range(9) == 0) return norm_t'($urandom);
    return norm_t'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic cull_fields_t rand_fields();
    logic [9*32-1:0] bits;
    for (int i = 0; i < 9; i++) bits[i*32 +: 32] = $urandom;
    return bits[$bits(cull_fields_t)-1:0];
  endfunction

  // A box of random extent up to span; now and then min and max are unrelated.
  function automatic cull_fields_t random_box(int unsigned span);
    cull_fields_t f;
    coord_t       lo[AXES];
    coord_t       hi[AXES];
    f = rand_fields();
    for (int a = 0; a < AXES; a++) begin
      lo[a] = rand_coord();
      if ($urandom_range(19) == 0) hi[a] = rand_coord();
      else hi[a] = lo[a] + coord_t'($urandom_range(0, span));
    end
    f.min_x = lo[0];
    f.min_y = lo[1];
    f.min_z = lo[2];
    f.max_x = hi[0];
    f.max_y = hi[1];
    f.max_z = hi[2];
    return f;
  endfunction

  // A plane load; one in ten targets an entry past the table.
  function automatic cull_fields_t random_plane();
    cull_fields_t f;
    f = rand_fields();
    if ($urandom_range(9) == 0) f.pidx = PIDX_W'($urandom_range(MAX_PLANES, 7));
    else f.pidx = PIDX_W'($urandom_range(0, MAX_PLANES - 1));
    f.nx     = rand_norm();
    f.ny     = rand_norm();
    f.nz     = rand_norm();
    f.offset = rand_coord();
    return f;
  endfunction

  function automatic cull_fields_t make_box(coord_t x0, coord_t y0, coord_t z0,
                                            coord_t x1, coord_t y1, coord_t z1);
    cull_fields_t f;
    f       = '0;
    f.min_x = x0;
    f.min_y = y0;
    f.min_z = z0;
    f.max_x = x1;
    f.max_y = y1;
    f.max_z = z1;
    return f;
  endfunction

  function automatic cull_fields_t make_plane(logic [PIDX_W-1:0] idx, norm_t x, norm_t y,
                                              norm_t z, coord_t off);
    cull_fields_t f;
    f        = '0;
    f.pidx   = idx;
    f.nx     = x;
    f.ny     = y;
    f.nz     = z;
    f.offset = off;
    return f;
  endfunction

  // One register write; cfg_we stays high so writes can follow back to back.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Writes all three registers (junk in the unused bits) and the unused index.
  task automatic set_config(int planes, bit region, bit frustum);
    write_cfg(CFG_PLANE_COUNT, CFG_DATA_W'(planes));
    write_cfg(CFG_USE_REGION, {2'($urandom), region});
    write_cfg(CFG_USE_FRUSTUM, {2'($urandom), frustum});
    write_cfg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Presents one item after a random idle gap and waits until it is taken.
  task automatic send_item(logic [IN_TUSER_W-1:0] mode, cull_fields_t f);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_TDATA_W'(f);
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, f);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Loads give no result, so allow the pipeline to empty before a register write.
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    cull_fields_t f;
    int           pick;
    int           done;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: everything on, plane_count above the table size.
    set_config(7, 1'b1, 1'b1);
    // State straight out of reset: zero region and zero planes pass the widest box.
    send_item(MODE_TEST, make_box(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
    send_item(MODE_REGION, make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    // Zero components on plane 0 select the maximum corner.
    send_item(MODE_PLANE, make_plane(3'd0, N_ONE, '0, '0, '0));
    send_item(MODE_PLANE, make_plane(3'd5, N_LO, N_LO, N_LO, COORD_HI));
    // Entries past the table and the unused mode must change nothing.
    send_item(MODE_PLANE, make_plane(3'd6, N_LO, N_HI, N_LO, COORD_LO));
    send_item(MODE_PLANE, make_plane(3'd7, N_HI, N_LO, N_HI, COORD_LO));
    send_item(MODE_UNUSED, rand_fields());
    send_item(MODE_TEST, make_box(Q_HALF, '0, '0, Q_ONE, Q_HALF, Q_HALF));
    send_item(MODE_TEST, make_box(-Q_ONE, '0, '0, -Q_HALF, Q_HALF, Q_HALF));
    send_item(MODE_TEST, make_box(Q_TWO, '0, '0, 32'sh0003_0000, Q_HALF, Q_HALF));
    // Inverted box, then one whose minimum touches the region's maximum.
    send_item(MODE_TEST, make_box(Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE));
    send_item(MODE_TEST, make_box(Q_ONE, -Q_ONE, -Q_ONE, Q_TWO, Q_ONE, Q_ONE));
    send_item(MODE_PLANE, make_plane(3'd1, N_HI, N_HI, N_HI, COORD_LO));
    send_item(MODE_TEST, make_box(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
    send_item(MODE_TEST, make_box('0, '0, '0, Q_HALF, Q_HALF, Q_HALF));
    // No planes counted: the frustum test passes; the region test is off.
    settle();
    set_config(0, 1'b0, 1'b1);
    send_item(MODE_TEST, make_box('0, '0, '0, Q_HALF, Q_HALF, Q_HALF));
    send_item(MODE_TEST, make_box(Q_TWO, Q_TWO, Q_TWO, 32'sh0003_0000, Q_TWO, Q_TWO));
    // Both tests off.
    settle();
    set_config(6, 1'b0, 1'b0);
    send_item(MODE_TEST, make_box(-Q_TWO, '0, '0, -Q_ONE, Q_HALF, Q_HALF));
    settle();
    set_config(1, 1'b1, 1'b1);
    send_item(MODE_TEST, make_box(-Q_ONE, '0, '0, -Q_HALF, Q_HALF, Q_HALF));
    send_item(MODE_TEST, make_box(Q_HALF, '0, '0, Q_ONE, Q_HALF, Q_HALF));

    // Random phases: each loads a region and a full plane table, then a mix of items.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      set_config(phase_planes[phase], phase_region[phase][0], phase_frustum[phase][0]);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 87; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 87; end
        default: begin sender_idle_pct = 15; stall_pct = 15; end
      endcase
      send_item(MODE_REGION, random_box(32'h8_0000));
      for (int p = 0; p < MAX_PLANES; p++) begin
        f      = random_plane();
        f.pidx = PIDX_W'(p);
        send_item(MODE_PLANE, f);
      end
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          f = random_box(32'h4_0000);
          send_item(MODE_TEST, f);
          done++;
        end else if (pick < 84) begin
          f = random_plane();
          send_item(MODE_PLANE, f);
          if (f.pidx < MAX_PLANES) done++;
        end else if (pick < 90) begin
          send_item(MODE_REGION, random_box(32'h8_0000));
          done++;
        end else if (pick < 96) begin
          // Box with every bit random.
          send_item(MODE_TEST, rand_fields());
          done++;
        end else begin
          send_item(MODE_UNUSED, rand_fields());
        end
        if ($urandom_range(199) == 0) wait_results();
      end
    end

    wait_results();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("aabb_frustum_region_cull: match");
    end else begin
      $display("aabb_frustum_region_cull: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("aabb_frustum_region_cull: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/afc_pkg.sv
rtl/core/aabb_frustum_region_cull.sv
tb/afc_visibility_sb_pkg.sv
tb/tb_aabb_frustum_region_cull.sv
